// File: sv/rpd_pkg.sv
package rpd_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 1024;

   localparam int BYTE_W = 8;
   localparam int KIND_W = 3;
   localparam int LEN_W  = 11;

   localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CHAR_HASH   = 8'h23;
   localparam logic [BYTE_W-1:0] CHAR_ESCAPE = 8'h7D;
   localparam logic [BYTE_W-1:0] ESCAPE_MASK = 8'h20;

   typedef enum logic [1:0] {
      PHASE_IDLE     = 2'd0,
      PHASE_PAYLOAD  = 2'd1,
      PHASE_CHECKSUM = 2'd2
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA     = 3'd0,
      KIND_GOOD     = 3'd1,
      KIND_MISMATCH = 3'd2,
      KIND_OVERFLOW = 3'd3,
      KIND_BADDIGIT = 3'd4
   } kind_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   // Accept 0-9, A-F and a-f.
   function automatic hex_digit_type hex_decode(input logic [BYTE_W-1:0] c);
      hex_digit_type d;
      d.valid = 1'b1;
      d.value = c[3:0];
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         d.value = c[3:0] + 4'd9;
      end else begin
         d.valid = 1'b0;
         d.value = 4'd0;
      end
      return d;
   endfunction

endpackage

// File: sv/rsp_packet_deframer.sv
// Packet deframer for $payload#hh frames, one received character per item.
// Input channel req_: req_rx_byte with req_valid / req_ready. Result channel
// rsp_: rsp_kind, rsp_payload_byte, rsp_frame_length with rsp_valid /
// rsp_ready. Each payload byte comes out unescaped as kind data; after the
// two checksum digits comes one end item (good or mismatch). A bad checksum
// digit or a payload longer than MAX_PAYLOAD ends the frame with its own
// kind. Characters outside a frame, the '$', the '#', escape marks and the
// first checksum digit give no result.
// Latency: a result is valid the cycle after its character is accepted.
// Throughput: one character every cycle unless the result stalls; the frame
// state and running sum are updated when the character is accepted and the
// result lands in one output register.
// Stall: while the result register is full and rsp_ready is low, req_ready
// is low and all state holds; with rsp_ready high a new character is taken
// in the same cycle the old result leaves.
// Reset: synchronous, active high; clears the result valid flag and returns
// the deframer to idle, waiting for '$'.
module rsp_packet_deframer
   import rpd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [BYTE_W-1:0] rsp_payload_byte,
   output logic [LEN_W-1:0]  rsp_frame_length
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

   phase_type          phase_ff, phase_in;
   logic               escape_ff, escape_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [BYTE_W-1:0]  recv_ff, recv_in;
   logic               digit_ff, digit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           kind_ff, kind_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic [LEN_W-1:0]   len_ff, len_in;

   logic               accept;
   logic               emit;
   kind_type           emit_kind;
   logic [BYTE_W-1:0]  emit_byte;
   logic [CNT_W-1:0]   emit_count;
   logic [CNT_W+LEN_W-1:0] count_ext;
   hex_digit_type      digit;
   logic [BYTE_W-1:0]  recv_full;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign digit     = hex_decode(req_rx_byte);
   assign recv_full = {recv_ff[BYTE_W-1:4], digit.value};

   always_comb begin
      phase_in   = phase_ff;
      escape_in  = escape_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      recv_in    = recv_ff;
      digit_in   = digit_ff;
      emit       = 1'b0;
      emit_kind  = KIND_DATA;
      emit_byte  = '0;
      emit_count = count_ff;
      case (phase_ff)
         PHASE_PAYLOAD: begin
            if (req_rx_byte == CHAR_HASH) begin
               phase_in = PHASE_CHECKSUM;
            end else begin
               sum_in = sum_ff + req_rx_byte;
               if (req_rx_byte == CHAR_ESCAPE && !escape_ff) begin
                  escape_in = 1'b1;
               end else if (count_ff >= CNT_MAX) begin
                  phase_in  = PHASE_IDLE;
                  emit      = 1'b1;
                  emit_kind = KIND_OVERFLOW;
               end else begin
                  escape_in  = 1'b0;
                  count_in   = count_ff + 1'b1;
                  emit       = 1'b1;
                  emit_kind  = KIND_DATA;
                  emit_byte  = escape_ff ? (req_rx_byte ^ ESCAPE_MASK) : req_rx_byte;
                  emit_count = count_ff + 1'b1;
               end
            end
         end
         PHASE_CHECKSUM: begin
            if (!digit.valid) begin
               phase_in  = PHASE_IDLE;
               emit      = 1'b1;
               emit_kind = KIND_BADDIGIT;
            end else if (!digit_ff) begin
               recv_in  = {digit.value, 4'd0};
               digit_in = 1'b1;
            end else begin
               recv_in   = recv_full;
               digit_in  = 1'b0;
               phase_in  = PHASE_IDLE;
               emit      = 1'b1;
               emit_kind = (recv_full == sum_ff) ? KIND_GOOD : KIND_MISMATCH;
            end
         end
         default: begin
            phase_in = PHASE_IDLE;
            if (req_rx_byte == CHAR_DOLLAR) begin
               phase_in  = PHASE_PAYLOAD;
               escape_in = 1'b0;
               sum_in    = '0;
               count_in  = '0;
               recv_in   = '0;
               digit_in  = 1'b0;
            end
         end
      endcase
   end

   // Frame length is the low bits of the count, zero-extended if narrower.
   assign count_ext = {{LEN_W{1'b0}}, emit_count};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      len_in       = len_ff;
      if (accept) begin
         rsp_valid_in = emit;
         if (emit) begin
            kind_in = emit_kind;
            byte_in = emit_byte;
            len_in  = count_ext[LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         escape_ff    <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         recv_ff      <= '0;
         digit_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff  <= phase_in;
            escape_ff <= escape_in;
            sum_ff    <= sum_in;
            count_ff  <= count_in;
            recv_ff   <= recv_in;
            digit_ff  <= digit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      len_ff  <= len_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_frame_length = len_ff;

   a_byte_zero_unless_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff != KIND_DATA |-> byte_ff == '0)
      else $error("payload byte not zero on a frame end item");

   a_end_returns_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff != KIND_DATA |-> phase_ff == PHASE_IDLE)
      else $error("frame end item while deframer is not idle");

   a_data_from_payload: assert property (@(posedge clock) disable iff (reset)
      accept && emit && emit_kind == KIND_DATA |=> phase_ff == PHASE_PAYLOAD)
      else $error("payload item left the payload phase");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(count_ff)
         && $stable(phase_ff))
      else $error("state moved while result stalled");

endmodule
